// ----- design/stst_pkg.sv -----
// Shared types and constants for the software timer slot table.
package stst_pkg;

	localparam int ID_W  = 32;
	localparam int DC_W  = 6;

	localparam logic [1:0] ACT_REG   = 2'd0;
	localparam logic [1:0] ACT_UNREG = 2'd1;
	localparam logic [1:0] ACT_RANGE = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	typedef struct packed {
		logic [1:0]      action;
		logic [ID_W-1:0] tid;
		logic [ID_W-1:0] range_top;
		logic [ID_W-1:0] period;
		logic            repeating;
		logic [ID_W-1:0] now_tick;
		logic            bad;       // rejected before any scan
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] key;
		logic [ID_W-1:0] deadline;
		logic [ID_W-1:0] period;
		logic            repeat_en;
		logic            wrapped;
		logic            dly_mark;
	} slot_t;

endpackage

// ----- design/stst_front.sv -----
// Request intake: decode of the rejection cases and a two-entry request queue.
module stst_front import stst_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      action,
	input  logic [ID_W-1:0] tid,
	input  logic [ID_W-1:0] range_top,
	input  logic [ID_W-1:0] period,
	input  logic            repeating,
	input  logic [ID_W-1:0] now_tick,
	output logic            req_valid,
	input  logic            req_pop,
	output req_t            req
);

	req_t       q_mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	req_t       dec;
	logic       push;

	always_comb begin
		dec.action    = action;
		dec.tid       = tid;
		dec.range_top = range_top;
		dec.period    = period;
		dec.repeating = repeating;
		dec.now_tick  = now_tick;
		unique case (action)
			ACT_REG:   dec.bad = (tid == '0) || (period == '0);
			ACT_UNREG: dec.bad = (tid == '0);
			ACT_RANGE: dec.bad = (tid == '0) || (range_top == '0);
			default:   dec.bad = 1'b0;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (req_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, req_pop};
		end
	end

endmodule

// ----- design/stst_engine.sv -----
// Slot table engine: sequential slot scan, fire list and result register.
module stst_engine import stst_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_pop,
	input  req_t            req,
	input  logic [ID_W-1:0] delay_lo,
	input  logic [ID_W-1:0] delay_hi,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_status,
	output logic            out_fired,
	output logic [ID_W-1:0] out_id,
	output logic [DC_W-1:0] out_dcount,
	output logic            out_last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_DRAIN   = 3'd2;
	localparam logic [2:0] S_FIN     = 3'd3;
	localparam logic [2:0] S_EMIT_RD = 3'd4;
	localparam logic [2:0] S_EMIT_LD = 3'd5;
	localparam logic [2:0] S_CLOSE   = 3'd6;

	slot_t           slot_mem [SLOTS];
	logic [ID_W-1:0] fire_mem [SLOTS];
	logic [SLOTS-1:0] valid_q;

	logic [2:0]      state_q;
	req_t            cur_q;
	logic [IW-1:0]   ptr_q;
	logic            twrap_q;
	logic [ID_W-1:0] prev_q;
	logic [CW-1:0]   total_q;
	logic [CW-1:0]   fcnt_q;
	logic [CW-1:0]   rd_q;
	logic            found_q;
	logic            mfound_q;
	logic [IW-1:0]   midx_q;
	logic            mdelay_q;
	logic            ffound_q;
	logic [IW-1:0]   fidx_q;
	logic            status_q;
	logic [ID_W-1:0] fid_q;

	logic            v_s1;
	logic [IW-1:0]   addr_s1;
	slot_t           raw_s1;
	logic            vld_s1;

	logic            out_valid_q;
	logic            out_status_q;
	logic            out_fired_q;
	logic [ID_W-1:0] out_id_q;
	logic [DC_W-1:0] out_dc_q;
	logic            out_last_q;

	// scan stage
	slot_t           e;
	slot_t           e_new;
	logic            s1_we;
	logic            s1_free;
	logic            s1_fire;
	logic            s1_hit_unreg;
	logic [ID_W:0]   rearm_sum;

	// final register write
	logic [ID_W:0]   reg_sum;
	logic            reg_inrange;
	logic            reg_ok;
	slot_t           reg_ent;

	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	slot_t           wr_data;
	logic            rd_en;
	logic            out_free;
	logic            out_load_fire;
	logic            out_load_close;

	assign out_free = !out_valid_q || out_ready;
	assign req_pop  = (state_q == S_IDLE) && req_valid;
	assign rd_en    = (state_q == S_SCAN);

	always_comb begin
		e = vld_s1 ? raw_s1 : '0;
		if (cur_q.action == ACT_TICK && twrap_q) begin
			e.wrapped = 1'b0;
		end
		e_new        = e;
		s1_we        = 1'b0;
		s1_free      = 1'b0;
		s1_fire      = 1'b0;
		s1_hit_unreg = 1'b0;
		rearm_sum    = {1'b0, cur_q.now_tick} + {1'b0, e.period};
		if (v_s1) begin
			unique case (cur_q.action)
				ACT_TICK: begin
					s1_we = 1'b1;
					if (e.key != '0 && !e.wrapped && e.deadline <= cur_q.now_tick) begin
						s1_fire = 1'b1;
						if (e.repeat_en && e.period != '0) begin
							e_new.deadline = rearm_sum[ID_W-1:0];
							e_new.wrapped  = rearm_sum[ID_W];
						end else begin
							s1_free = 1'b1;
						end
					end
				end
				ACT_UNREG: begin
					if (!found_q && e.key == cur_q.tid) begin
						s1_hit_unreg = 1'b1;
						s1_we        = 1'b1;
						s1_free      = 1'b1;
					end
				end
				ACT_RANGE: begin
					if (e.key >= cur_q.tid && e.key <= cur_q.range_top) begin
						s1_we   = 1'b1;
						s1_free = 1'b1;
					end
				end
				default: ;
			endcase
			if (s1_free) begin
				e_new = '0;
			end
		end
	end

	always_comb begin
		reg_sum     = {1'b0, prev_q} + {1'b0, cur_q.period};
		reg_inrange = (cur_q.tid >= delay_lo) && (cur_q.tid <= delay_hi);
		reg_ok      = mfound_q || ffound_q;
		reg_ent.key       = cur_q.tid;
		reg_ent.deadline  = reg_sum[ID_W-1:0];
		reg_ent.period    = cur_q.period;
		reg_ent.repeat_en = cur_q.repeating;
		reg_ent.wrapped   = reg_sum[ID_W];
		reg_ent.dly_mark  = (mfound_q && mdelay_q) || reg_inrange;
	end

	always_comb begin
		if (state_q == S_FIN) begin
			wr_en   = (cur_q.action == ACT_REG) && reg_ok;
			wr_addr = mfound_q ? midx_q : fidx_q;
			wr_data = reg_ent;
		end else begin
			wr_en   = s1_we;
			wr_addr = addr_s1;
			wr_data = e_new;
		end
	end

	assign out_load_fire  = (state_q == S_EMIT_LD) && out_free;
	assign out_load_close = (state_q == S_CLOSE) && out_free;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_s1 <= slot_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fire_mem[fcnt_q[IW-1:0]] <= e.key;
		end
		if (state_q == S_EMIT_RD && rd_q < fcnt_q) begin
			fid_q <= fire_mem[rd_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
		end
		if (rd_en) begin
			addr_s1 <= ptr_q;
		end
		if (out_load_fire || out_load_close) begin
			out_status_q <= out_load_fire ? 1'b0 : status_q;
			out_fired_q  <= out_load_fire;
			out_id_q     <= out_load_fire ? fid_q : '0;
			out_dc_q     <= DC_W'(total_q);
			out_last_q   <= out_load_close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			vld_s1      <= 1'b0;
			v_s1        <= 1'b0;
			ptr_q       <= '0;
			twrap_q     <= 1'b0;
			prev_q      <= '0;
			total_q     <= '0;
			fcnt_q      <= '0;
			rd_q        <= '0;
			found_q     <= 1'b0;
			mfound_q    <= 1'b0;
			midx_q      <= '0;
			mdelay_q    <= 1'b0;
			ffound_q    <= 1'b0;
			fidx_q      <= '0;
			status_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (rd_en) begin
				vld_s1 <= valid_q[ptr_q];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (s1_fire) begin
				fcnt_q <= fcnt_q + 1'b1;
			end
			if (s1_hit_unreg) begin
				found_q <= 1'b1;
			end
			if (s1_free && e.dly_mark && total_q != '0) begin
				total_q <= total_q - 1'b1;
			end
			if (v_s1 && cur_q.action == ACT_REG) begin
				if (!mfound_q && e.key == cur_q.tid) begin
					mfound_q <= 1'b1;
					midx_q   <= addr_s1;
					mdelay_q <= e.dly_mark;
				end
				if (!ffound_q && e.key == '0) begin
					ffound_q <= 1'b1;
					fidx_q   <= addr_s1;
				end
			end

			if (out_load_fire || out_load_close) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						ptr_q    <= '0;
						fcnt_q   <= '0;
						rd_q     <= '0;
						found_q  <= 1'b0;
						mfound_q <= 1'b0;
						ffound_q <= 1'b0;
						if (req.action == ACT_TICK) begin
							twrap_q <= (req.now_tick < prev_q);
							prev_q  <= req.now_tick;
							state_q <= S_SCAN;
						end else if (req.bad) begin
							status_q <= 1'b1;
							state_q  <= S_CLOSE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == IW'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					unique case (cur_q.action)
						ACT_REG: begin
							status_q <= !reg_ok;
							if (reg_ok && reg_inrange && !(mfound_q && mdelay_q)
								&& total_q < CW'(SLOTS)) begin
								total_q <= total_q + 1'b1;
							end
						end
						ACT_UNREG: status_q <= !found_q;
						default:   status_q <= 1'b0;
					endcase
					state_q <= (cur_q.action == ACT_TICK) ? S_EMIT_RD : S_CLOSE;
				end
				S_EMIT_RD: begin
					state_q <= (rd_q < fcnt_q) ? S_EMIT_LD : S_CLOSE;
				end
				S_EMIT_LD: begin
					if (out_free) begin
						rd_q    <= rd_q + 1'b1;
						state_q <= S_EMIT_RD;
					end
				end
				S_CLOSE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_fired  = out_fired_q;
	assign out_id     = out_id_q;
	assign out_dcount = out_dc_q;
	assign out_last   = out_last_q;

`ifndef SYNTHESIS
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("scan stage active outside scan");
	a_fcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CW'(SLOTS))
		else $error("fire list overflow");
	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(SLOTS))
		else $error("delay count above slot count");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_LD) |-> (rd_q < fcnt_q))
		else $error("emit past fire list");
`endif

endmodule

// ----- design/software_timer_slot_table_top.sv -----
// Top level of the software timer slot table.
//
// Requests come in on s_axis (tvalid/tready/tdata); each request is one of
// register, unregister, range unregister or tick. Results leave on m_axis:
// tdata carries status, fired id and the live delay-entry count, tuser is
// the fired flag and tlast marks the closing result of a request. A tick
// gives one result per expired slot in slot order, then a closing result;
// every other request gives one result.
// Delay-range bounds are written through cfg_we/cfg_index/cfg_wdata
// (index 0 low bound, index 1 high bound); the user must write them only
// while the block is idle, which the block itself does not enforce.
// A two-entry request queue decouples intake from the engine, which walks
// the slot memory one slot per cycle. Register, unregister, range and tick
// requests scan every slot before their result; a tick then gives its
// fired results before the closing one. The engine takes the next request
// once the closing result is loaded, so requests do not overlap; the slot
// memory scan bounds the request rate. Rejected requests skip the scan.
// The result register lets the engine finish its work while the receiver
// stalls; the engine then waits with the next result.
// Reset clears the slot valid bits, tick count, delay count and bounds.
module software_timer_slot_table_top import stst_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[1:0], tid[33:2], range_top[65:34], period[97:66],
	// repeating[98], now_tick[130:99], zero fill
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[0], fired_id[32:1], delay_count[38:33], zero fill
	output logic [39:0]  m_axis_tdata,
	// fired[0]
	output logic         m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);

	localparam logic CFG_DELAY_LO = 1'b0;
	localparam logic CFG_DELAY_HI = 1'b1;

	logic [ID_W-1:0] delay_lo_q;
	logic [ID_W-1:0] delay_hi_q;
	logic            req_valid;
	logic            req_pop;
	req_t            req;
	logic            status;
	logic [ID_W-1:0] fired_id;
	logic [DC_W-1:0] dcount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_lo_q <= '0;
			delay_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELAY_LO: delay_lo_q <= cfg_wdata;
				CFG_DELAY_HI: delay_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	stst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.action    (s_axis_tdata[1:0]),
		.tid       (s_axis_tdata[33:2]),
		.range_top (s_axis_tdata[65:34]),
		.period    (s_axis_tdata[97:66]),
		.repeating (s_axis_tdata[98]),
		.now_tick  (s_axis_tdata[130:99]),
		.req_valid (req_valid),
		.req_pop   (req_pop),
		.req       (req)
	);

	stst_engine #(.SLOTS(SLOTS)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_pop    (req_pop),
		.req        (req),
		.delay_lo   (delay_lo_q),
		.delay_hi   (delay_hi_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_fired  (m_axis_tuser),
		.out_id     (fired_id),
		.out_dcount (dcount),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, dcount, fired_id, status};

endmodule

// ----- tb/software_timer_slot_table_checker.sv -----
// Checker for the timer slot table: predicts results of each request and compares them.
`timescale 1ns / 1ps
module software_timer_slot_table_checker import stst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata,
	output int           fail_count,
	output int           pending
);
	localparam int N = 32;

	typedef struct packed {
		logic        status;
		logic        fired;
		logic [31:0] fired_id;
		logic [5:0]  delay_count;
		logic        last;
	} timer_result_t;

	timer_result_t due_q[$];
	logic [31:0] lo_bound, hi_bound, last_tick;
	logic [5:0]  live_delays;
	slot_t       tbl [N];

	assign pending = due_q.size();

	function automatic void drop_slot(int i);
		if (tbl[i].dly_mark && live_delays > 0) live_delays--;
		tbl[i] = '0;
	endfunction

	task automatic predict_request(input logic [135:0] d);
		logic [1:0]  act;
		logic [31:0] id, top, per, now;
		logic        rep, st;
		int          pick, n0;
		timer_result_t r;
		act = d[1:0]; id = d[33:2]; top = d[65:34]; per = d[97:66];
		rep = d[98]; now = d[130:99];
		n0 = due_q.size();
		st = 1'b0;
		case (act)
		ACT_REG: begin
			pick = -1;
			if (id == 0 || per == 0) st = 1'b1;
			else begin
				for (int i = 0; i < N; i++) begin
					if (tbl[i].key == id) begin
						pick = i;
						break;
					end
					if (tbl[i].key == 0 && pick < 0) pick = i;
				end
				if (pick < 0) st = 1'b1;
				else begin
					tbl[pick].key = id;
					tbl[pick].period = per;
					tbl[pick].repeat_en = rep;
					tbl[pick].deadline = last_tick + per;
					tbl[pick].wrapped = (last_tick + per) < last_tick;
					if (id >= lo_bound && id <= hi_bound && !tbl[pick].dly_mark) begin
						tbl[pick].dly_mark = 1'b1;
						if (live_delays < N) live_delays++;
					end
				end
			end
		end
		ACT_UNREG: begin
			st = 1'b1;
			if (id != 0)
				for (int i = 0; i < N; i++)
					if (tbl[i].key == id) begin
						drop_slot(i);
						st = 1'b0;
						break;
					end
		end
		ACT_RANGE: begin
			if (id == 0 || top == 0) st = 1'b1;
			else
				for (int i = N - 1; i >= 0; i--)
					if (tbl[i].key >= id && tbl[i].key <= top) drop_slot(i);
		end
		default: begin
			if (now < last_tick)
				for (int i = 0; i < N; i++) tbl[i].wrapped = 1'b0;
			last_tick = now;
			for (int i = 0; i < N; i++)
				if (tbl[i].key != 0 && !tbl[i].wrapped && tbl[i].deadline <= now) begin
					r = '{1'b0, 1'b1, tbl[i].key, 6'd0, 1'b0};
					due_q.push_back(r);
					if (tbl[i].repeat_en && tbl[i].period > 0) begin
						tbl[i].deadline = now + tbl[i].period;
						if (tbl[i].deadline < now) tbl[i].wrapped = 1'b1;
					end else drop_slot(i);
				end
		end
		endcase
		r = '{st, 1'b0, 32'd0, 6'd0, 1'b1};
		due_q.push_back(r);
		// count is reported as of the end of the whole request
		for (int k = n0; k < due_q.size(); k++) due_q[k].delay_count = live_delays;
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t got, exp_r;
		if (!arst_n) begin
			lo_bound = '0; hi_bound = '0; last_tick = '0; live_delays = '0;
			for (int i = 0; i < N; i++) tbl[i] = '0;
			due_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) hi_bound = cfg_wdata;
				else lo_bound = cfg_wdata;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[0], m_axis_tuser, m_axis_tdata[32:1],
					m_axis_tdata[38:33], m_axis_tlast};
				if (due_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %h", got);
					fail_count = fail_count + 1;
				end else begin
					exp_r = due_q.pop_front();
					if (got !== exp_r) begin
						if (fail_count < 10)
							$display({"mismatch: exp st=%b f=%b id=%h dc=%0d l=%b",
								" got st=%b f=%b id=%h dc=%0d l=%b"},
								exp_r.status, exp_r.fired, exp_r.fired_id,
								exp_r.delay_count, exp_r.last, got.status,
								got.fired, got.fired_id, got.delay_count, got.last);
						fail_count = fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tdata);
		end
	end
endmodule

// ----- tb/software_timer_slot_table_top_test.sv -----
// Stimulus and verdict for the timer slot table regression.
`timescale 1ns / 1ps
module software_timer_slot_table_top_test;
	import stst_pkg::*;

	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid, m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         m_axis_tuser, m_axis_tlast;
	logic         cfg_we, cfg_index;
	logic [31:0]  cfg_wdata;
	int           fail_count, pending;
	int           send_idle, recv_idle; // percent of cycles each side stalls
	int           quiet_cycles;
	logic [31:0]  tick_now;             // running tick value for well-formed ticks

	software_timer_slot_table_top #(.SLOTS(32)) dut (.*);
	software_timer_slot_table_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stall, redrawn every falling edge.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle);

	// Watchdog: cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [135:0] pack_request(logic [1:0] act, logic [31:0] id,
		logic [31:0] top, logic [31:0] per, logic rep, logic [31:0] now);
		return {5'd0, now, rep, per, top, id, act};
	endfunction

	// One request: optional sender gap, then hold until accepted. Returns at the
	// falling edge after acceptance with tvalid still up; the caller either
	// sends the next request or calls stop_sending at that same edge.
	task automatic send_request(input logic [135:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		// tready only moves at a rising edge, so it is stable here
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	// Drain, then let the engine go quiet before touching the bounds.
	task automatic write_bounds(input logic [31:0] lo, input logic [31:0] hi);
		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= 1'b0; cfg_wdata <= lo;
		@(negedge clk);
		cfg_index <= 1'b1; cfg_wdata <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Small id pool so registers, unregisters and ranges collide often.
	function automatic logic [31:0] pick_id();
		case ($urandom_range(9))
		0:       return $urandom;
		1:       return 32'hFFFF_FFFF - $urandom_range(3);
		default: return $urandom_range(40);
		endcase
	endfunction

	task automatic random_phase(input int count);
		logic [31:0] id, per;
		int          sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			id  = pick_id();
			per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20);
			if (sel < 45)
				send_request(pack_request(ACT_REG, id, $urandom, per, $urandom_range(1),
					$urandom));
			else if (sel < 55)
				send_request(pack_request(ACT_UNREG, id, $urandom, $urandom,
					$urandom_range(1), $urandom));
			else if (sel < 62)
				send_request(pack_request(ACT_RANGE, id, id + $urandom_range(8), $urandom,
					$urandom_range(1), $urandom));
			else begin
				// mostly forward ticks, sometimes a jump that wraps the counter
				if ($urandom_range(9) == 0) tick_now = $urandom;
				else tick_now = tick_now + $urandom_range(12);
				send_request(pack_request(ACT_TICK, $urandom, $urandom, $urandom,
					$urandom_range(1), tick_now));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
		send_idle = 26; recv_idle = 76;
		quiet_cycles = 0; tick_now = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_bounds(32'd1, 32'd10);
		// Directed: rejects, extremes, wraps, re-register of a delay slot.
		send_request(pack_request(ACT_REG, 32'd0, 0, 32'd5, 1'b1, 0));
		send_request(pack_request(ACT_REG, 32'd3, 0, 32'd0, 1'b1, 0));
		send_request(pack_request(ACT_REG, 32'd3, 0, 32'd5, 1'b1, 0));
		send_request(pack_request(ACT_REG, 32'd3, 0, 32'd7, 1'b0, 0));
		send_request(pack_request(ACT_REG, 32'hFFFF_FFFF, '1, '1, 1'b1, '1));
		send_request(pack_request(ACT_REG, 32'd9, 0, 32'd1, 1'b0, 0));
		send_request(pack_request(ACT_UNREG, 32'd0, 0, 0, 1'b0, 0));
		send_request(pack_request(ACT_UNREG, 32'd77, 0, 0, 1'b0, 0));
		send_request(pack_request(ACT_RANGE, 32'd0, 32'd5, 0, 1'b0, 0));
		send_request(pack_request(ACT_RANGE, 32'd8, 32'd2, 0, 1'b0, 0));
		send_request(pack_request(ACT_TICK, 0, 0, 0, 1'b0, 32'd7));
		send_request(pack_request(ACT_REG, 32'd5, 0, 32'hFFFF_FFF0, 1'b1, 0));
		send_request(pack_request(ACT_TICK, 0, 0, 0, 1'b0, 32'hFFFF_FFFF));
		send_request(pack_request(ACT_TICK, 0, 0, 0, 1'b0, 32'd2));
		send_request(pack_request(ACT_TICK, 0, 0, 0, 1'b0, 32'd0));
		for (int i = 1; i <= 33; i++)
			send_request(pack_request(ACT_REG, i, 0, 32'd4, i[0], 0));
		send_request(pack_request(ACT_TICK, 0, 0, 0, 1'b0, 32'd100));
		send_request(pack_request(ACT_RANGE, 32'd1, 32'hFFFF_FFFF, 0, 1'b0, 0));
		send_request(pack_request(ACT_UNREG, 32'd3, 0, 0, 1'b0, 0));

		// Hold off until the queue of expected results is empty.
		stop_sending();
		while (pending != 0) @(negedge clk);
		tick_now = 32'd100;
		random_phase(35);

		write_bounds(32'd0, 32'hFFFF_FFFF);
		send_idle = 76; recv_idle = 26;
		random_phase(35);

		write_bounds(32'd20, 32'd5);
		send_idle = 0; recv_idle = 0;
		random_phase(15);
		write_bounds(32'hFFFF_FFFC, 32'hFFFF_FFFF);
		random_phase(15);

		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
